// ===== hdl/mdsm_pkg.sv =====
// shared types and constants of the multi-deck sample mixer
// no dependencies
package mdsm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int TBL_AW = 11;
	localparam int TBL_MID = 512;
	localparam int TBL_LAST = 1024;
	localparam int FRAC_W = 22;
	localparam logic [31:0] EXP_STEP = 32'd4228380000;
	localparam logic [15:0] UNITY_GAIN = 16'd16384;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_VOL = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_VOL = 2'd1,
		OP_TICK = 2'd2
	} op_t;

	typedef struct packed {
		op_t op;
		logic [1:0] deck;
		logic signed [SAMPLE_W-1:0] sample;
		logic [15:0] volume;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic we;
		logic [TBL_AW-1:0] addr;
		logic [15:0] data;
	} tbl_wr_t;

endpackage

// ===== hdl/mdsm_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module mdsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hdl/mdsm_front.sv =====
// front end: takes requests, drops the meaningless ones, holds a two-entry command queue
// depends on mdsm_pkg
module mdsm_front import mdsm_pkg::*; #(
	parameter int NUM_DECKS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 mode,
	input  logic [1:0]                 deck,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [15:0]                volume,
	input  logic                       last,
	input  logic                       table_ready,
	input  logic                       deq,
	output logic                       cmd_valid,
	output cmd_t                       cmd
);
	cmd_t ent_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] cnt_q;
	logic accept;
	logic keep;
	logic deck_ok;
	cmd_t in_cmd;

	assign full = !table_ready || (cnt_q == 2'd2);
	assign accept = push && !full;
	assign deck_ok = 5'(deck) < 5'(NUM_DECKS);

	always_comb begin
		in_cmd.deck = deck;
		in_cmd.sample = sample;
		in_cmd.volume = volume;
		in_cmd.last = last;
		in_cmd.op = OP_TICK;
		keep = 1'b0;
		case (mode)
			MODE_LOAD: begin
				in_cmd.op = OP_LOAD;
				keep = deck_ok;
			end
			MODE_VOL: begin
				in_cmd.op = OP_VOL;
				keep = deck_ok;
			end
			MODE_TICK: begin
				in_cmd.op = OP_TICK;
				keep = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accept && keep) begin
				ent_q[wp_q] <= in_cmd;
				wp_q <= !wp_q;
			end
			if (deq && cmd_valid) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'((accept && keep) ? 1 : 0) - 2'((deq && cmd_valid) ? 1 : 0);
		end
	end

	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = ent_q[rp_q];
endmodule

// ===== hdl/mdsm_tbl_init.sv =====
// builds the tanh table after reset: exp recurrence by shift-add, quotient by restoring division
// depends on mdsm_pkg
module mdsm_tbl_init import mdsm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	output tbl_wr_t wr,
	output logic    ready
);
	typedef enum logic [2:0] {
		IN_PREP,
		IN_DIV,
		IN_WPOS,
		IN_WNEG,
		IN_MPREP,
		IN_MUL,
		IN_NEXT,
		IN_DONE
	} in_state_t;

	in_state_t state_q;
	logic [9:0] j_q;
	logic [32:0] e_q;
	logic [48:0] rem_q;
	logic [48:0] dsh_q;
	logic [15:0] q_q;
	logic [3:0] b_q;
	logic [64:0] acc_q;
	logic [64:0] mc_q;
	logic [31:0] rr_q;
	logic [4:0] c_q;
	logic [32:0] num;
	logic [33:0] den;

	assign num = 33'h1_0000_0000 - e_q;
	assign den = 34'h1_0000_0000 + 34'(e_q);

	always_comb begin
		wr.we = (state_q == IN_WPOS) || (state_q == IN_WNEG);
		if (state_q == IN_WNEG) begin
			wr.addr = TBL_AW'(TBL_MID) - TBL_AW'(j_q);
			wr.data = 16'd32768 - q_q;
		end else begin
			wr.addr = TBL_AW'(TBL_MID) + TBL_AW'(j_q);
			wr.data = 16'd32768 + q_q;
		end
	end

	assign ready = (state_q == IN_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IN_PREP;
			j_q <= '0;
			e_q <= 33'h1_0000_0000;
			rem_q <= '0;
			dsh_q <= '0;
			q_q <= '0;
			b_q <= '0;
			acc_q <= '0;
			mc_q <= '0;
			rr_q <= '0;
			c_q <= '0;
		end else begin
			case (state_q)
				IN_PREP: begin
					rem_q <= {1'b0, num, 15'd0} + 49'(den >> 1);
					dsh_q <= {den, 15'd0};
					q_q <= '0;
					b_q <= 4'd15;
					state_q <= IN_DIV;
				end
				IN_DIV: begin
					if (rem_q >= dsh_q) begin
						rem_q <= rem_q - dsh_q;
						q_q <= {q_q[14:0], 1'b1};
					end else begin
						q_q <= {q_q[14:0], 1'b0};
					end
					dsh_q <= dsh_q >> 1;
					if (b_q == 4'd0) begin
						state_q <= IN_WPOS;
					end else begin
						b_q <= b_q - 4'd1;
					end
				end
				IN_WPOS: state_q <= IN_WNEG;
				IN_WNEG: begin
					if (j_q == 10'(TBL_MID)) begin
						state_q <= IN_DONE;
					end else begin
						state_q <= IN_MPREP;
					end
				end
				IN_MPREP: begin
					acc_q <= 65'h8000_0000;
					mc_q <= 65'(e_q);
					rr_q <= EXP_STEP;
					c_q <= 5'd31;
					state_q <= IN_MUL;
				end
				IN_MUL: begin
					if (rr_q[0]) begin
						acc_q <= acc_q + mc_q;
					end
					mc_q <= mc_q << 1;
					rr_q <= rr_q >> 1;
					if (c_q == 5'd0) begin
						state_q <= IN_NEXT;
					end else begin
						c_q <= c_q - 5'd1;
					end
				end
				IN_NEXT: begin
					e_q <= acc_q[64:32];
					j_q <= j_q + 10'd1;
					state_q <= IN_PREP;
				end
				IN_DONE: state_q <= IN_DONE;
				default: state_q <= IN_PREP;
			endcase
		end
	end
endmodule

// ===== hdl/mdsm_back.sv =====
// back end: carries out load, volume and tick commands, walks the decks, soft clips the mix
// depends on mdsm_pkg; sample and tanh memories sit in the top level
module mdsm_back import mdsm_pkg::*; #(
	parameter int NUM_DECKS = 4,
	parameter int DECK_DEPTH = 65536,
	localparam int AW = $clog2(DECK_DEPTH),
	localparam int SADDR_W = $clog2(NUM_DECKS * (2 ** AW))
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  cmd_t                       cmd,
	output logic                       deq,
	output logic                       s_we,
	output logic [SADDR_W-1:0]         s_waddr,
	output logic [SAMPLE_W-1:0]        s_wdata,
	output logic [SADDR_W-1:0]         s_raddr,
	input  logic [SAMPLE_W-1:0]        s_rdata,
	output logic [TBL_AW-1:0]          t_raddr,
	input  logic [15:0]                t_rdata,
	input  logic                       pop,
	output logic                       empty,
	output logic signed [SAMPLE_W-1:0] mixed_sample
);
	localparam int PW = $clog2(DECK_DEPTH + 1);
	localparam int DK_W = (NUM_DECKS > 1) ? $clog2(NUM_DECKS) : 1;
	localparam int MIX_W = 33 + $clog2(NUM_DECKS);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK,
		ST_MUL,
		ST_ACC,
		ST_CL_IDX,
		ST_CL_RD0,
		ST_CL_RD1,
		ST_CL_MUL,
		ST_CL_OUT
	} st_t;

	st_t state_q;
	logic [PW-1:0] pos_q [NUM_DECKS];
	logic [PW-1:0] len_q [NUM_DECKS];
	logic [PW-1:0] lptr_q [NUM_DECKS];
	logic [15:0] gain_q [NUM_DECKS];
	logic [NUM_DECKS-1:0] act_q;
	logic [NUM_DECKS-1:0] loading_q;
	logic [DK_W-1:0] k_q;
	logic signed [MIX_W-1:0] mix_q;
	logic signed [32:0] prod_q;
	logic [TBL_AW-1:0] tidx_q;
	logic [FRAC_W-1:0] f_q;
	logic [15:0] lo_q;
	logic signed [39:0] prod2_q;
	logic res_valid_q;
	logic signed [SAMPLE_W-1:0] res_q;

	logic [DK_W-1:0] idx;
	logic [PW-1:0] cur_pos;
	logic [PW-1:0] cur_len;
	logic [PW-1:0] cur_lptr;
	logic [15:0] cur_gain;
	logic cur_act;
	logic cur_loading;
	logic [PW-1:0] eff_ptr;
	logic room;
	logic [PW-1:0] new_ptr;
	logic playable;
	logic last_k;
	logic [TBL_AW-1:0] tnext;
	logic signed [MIX_W:0] u;
	logic signed [16:0] diff;
	logic [39:0] acc;

	assign idx = (state_q == ST_IDLE) ? DK_W'(cmd.deck) : k_q;
	assign cur_pos = pos_q[idx];
	assign cur_len = len_q[idx];
	assign cur_lptr = lptr_q[idx];
	assign cur_gain = gain_q[idx];
	assign cur_act = act_q[idx];
	assign cur_loading = loading_q[idx];

	// first sample of a load restarts the pointer
	assign eff_ptr = cur_loading ? cur_lptr : '0;
	assign room = eff_ptr < PW'(DECK_DEPTH);
	assign new_ptr = room ? eff_ptr + PW'(1) : eff_ptr;
	assign playable = cur_act && (cur_pos < cur_len) && (cur_pos < PW'(DECK_DEPTH));
	assign last_k = (k_q == DK_W'(NUM_DECKS - 1));

	assign deq = (state_q == ST_IDLE) && cmd_valid;
	assign s_we = deq && (cmd.op == OP_LOAD) && room;
	assign s_waddr = SADDR_W'({idx, eff_ptr[AW-1:0]});
	assign s_wdata = cmd.sample;
	assign s_raddr = SADDR_W'({k_q, cur_pos[AW-1:0]});

	assign tnext = (tidx_q == TBL_AW'(TBL_LAST)) ? tidx_q : tidx_q + TBL_AW'(1);
	assign t_raddr = (state_q == ST_CL_RD1) ? tnext : tidx_q;

	assign u = {mix_q[MIX_W-1], mix_q} + (MIX_W+1)'(64'd2147483648);
	assign diff = $signed({1'b0, t_rdata}) - $signed({1'b0, lo_q});
	assign acc = {2'b00, lo_q, 22'd0} + 40'(prod2_q) + 40'd2097152;

	assign empty = !res_valid_q;
	assign mixed_sample = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int d = 0; d < NUM_DECKS; d++) begin
				pos_q[d] <= '0;
				len_q[d] <= '0;
				lptr_q[d] <= '0;
				gain_q[d] <= UNITY_GAIN;
			end
			act_q <= '0;
			loading_q <= '0;
			k_q <= '0;
			mix_q <= '0;
			prod_q <= '0;
			tidx_q <= '0;
			f_q <= '0;
			lo_q <= '0;
			prod2_q <= '0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							OP_LOAD: begin
								lptr_q[idx] <= new_ptr;
								if (cmd.last) begin
									len_q[idx] <= new_ptr;
									gain_q[idx] <= cmd.volume;
									pos_q[idx] <= '0;
									act_q[idx] <= 1'b1;
									loading_q[idx] <= 1'b0;
								end else begin
									loading_q[idx] <= 1'b1;
									if (!cur_loading) begin
										act_q[idx] <= 1'b0;
									end
								end
							end
							OP_VOL: gain_q[idx] <= cmd.volume;
							OP_TICK: begin
								k_q <= '0;
								mix_q <= '0;
								state_q <= ST_CHK;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CHK: begin
					if (playable) begin
						pos_q[idx] <= cur_pos + PW'(1);
						state_q <= ST_MUL;
					end else begin
						if (cur_act) begin
							act_q[idx] <= 1'b0;
						end
						if (last_k) begin
							state_q <= ST_CL_IDX;
						end else begin
							k_q <= k_q + DK_W'(1);
						end
					end
				end
				ST_MUL: begin
					prod_q <= $signed(s_rdata) * $signed({1'b0, cur_gain});
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					mix_q <= mix_q + MIX_W'(prod_q);
					if (last_k) begin
						state_q <= ST_CL_IDX;
					end else begin
						k_q <= k_q + DK_W'(1);
						state_q <= ST_CHK;
					end
				end
				ST_CL_IDX: begin
					// saturate outside [-4,4) onto the end points of the table
					if (u[MIX_W]) begin
						tidx_q <= '0;
						f_q <= '0;
					end else if (|u[MIX_W-1:32]) begin
						tidx_q <= TBL_AW'(TBL_LAST);
						f_q <= '0;
					end else begin
						tidx_q <= {1'b0, u[31:FRAC_W]};
						f_q <= u[FRAC_W-1:0];
					end
					state_q <= ST_CL_RD0;
				end
				ST_CL_RD0: state_q <= ST_CL_RD1;
				ST_CL_RD1: begin
					lo_q <= t_rdata;
					state_q <= ST_CL_MUL;
				end
				ST_CL_MUL: begin
					prod2_q <= diff * $signed({1'b0, f_q});
					state_q <= ST_CL_OUT;
				end
				ST_CL_OUT: begin
					if (!res_valid_q) begin
						res_q <= {~acc[37], acc[36:22]};
						res_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/multi_deck_sample_mixer_core.sv =====
// top level of the multi-deck sample mixer
// depends on mdsm_pkg, mdsm_ram, mdsm_front, mdsm_tbl_init, mdsm_back
//
// Plays back up to NUM_DECKS decks of Q1.15 samples and mixes them through an
// interpolated tanh soft clip. Load and volume requests take effect when dequeued;
// a tick request leaves the queue, then walks the decks one at a time, with a check, a
// multiply and an accumulate for a playing deck, only the check for an idle one, then
// runs the clip (index, two table reads, one multiply, output); the deck walk sets the
// length of a tick, and the clip output waits while an earlier result is not popped.
// The two-entry command queue keeps accepting while the back end works or a result waits,
// until both entries are filled. After reset the tanh table is computed in place, during
// which full stays high.
module multi_deck_sample_mixer_core import mdsm_pkg::*; #(
	parameter int NUM_DECKS = 4,
	parameter int DECK_DEPTH = 65536
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 mode,
	input  logic [1:0]                 deck,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [15:0]                volume,
	input  logic                       last,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [SAMPLE_W-1:0] mixed_sample
);
	localparam int AW = $clog2(DECK_DEPTH);
	localparam int SDEPTH = NUM_DECKS * (2 ** AW);
	localparam int SADDR_W = $clog2(SDEPTH);

	logic table_ready;
	logic cmd_valid;
	logic deq;
	cmd_t cmd;
	tbl_wr_t tbl_wr;
	logic s_we;
	logic [SADDR_W-1:0] s_waddr;
	logic [SAMPLE_W-1:0] s_wdata;
	logic [SADDR_W-1:0] s_raddr;
	logic [SAMPLE_W-1:0] s_rdata;
	logic [TBL_AW-1:0] t_raddr;
	logic [15:0] t_rdata;

	mdsm_front #(.NUM_DECKS(NUM_DECKS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .mode(mode), .deck(deck),
		.sample(sample), .volume(volume), .last(last), .table_ready(table_ready),
		.deq(deq), .cmd_valid(cmd_valid), .cmd(cmd)
	);

	mdsm_tbl_init u_init (.clk(clk), .arst_n(arst_n), .wr(tbl_wr), .ready(table_ready));

	// table entries are held offset by one half so they read as unsigned
	mdsm_ram #(.WIDTH(16), .DEPTH(TBL_LAST + 1)) u_tbl_ram (
		.clk(clk), .we(tbl_wr.we), .waddr(tbl_wr.addr), .wdata(tbl_wr.data),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	mdsm_ram #(.WIDTH(SAMPLE_W), .DEPTH(SDEPTH)) u_sample_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	mdsm_back #(.NUM_DECKS(NUM_DECKS), .DECK_DEPTH(DECK_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd), .deq(deq),
		.s_we(s_we), .s_waddr(s_waddr), .s_wdata(s_wdata), .s_raddr(s_raddr),
		.s_rdata(s_rdata), .t_raddr(t_raddr), .t_rdata(t_rdata), .pop(pop),
		.empty(empty), .mixed_sample(mixed_sample)
	);
endmodule

// ===== hdl/mdsm_checker.sv =====
// port-level checks of the mixer, bound to the top level
// depends on mdsm_pkg and multi_deck_sample_mixer_core
module mdsm_checker import mdsm_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       push,
	input logic                       full,
	input logic [1:0]                 mode,
	input logic                       empty,
	input logic                       pop,
	input logic signed [SAMPLE_W-1:0] mixed_sample
);
	logic [3:0] pend_q;
	logic tick_in;
	logic res_out;

	assign tick_in = push && !full && (mode == MODE_TICK);
	assign res_out = pop && !empty;

	// ticks taken whose result has not yet been popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 4'(tick_in ? 1 : 0) - 4'(res_out ? 1 : 0);
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pend_q != 4'd0))
		else $error("result shown with no tick outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'd4)
		else $error("more ticks outstanding than the design can hold");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result withdrawn");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(mixed_sample))
		else $error("waiting result changed");
endmodule

bind multi_deck_sample_mixer_core mdsm_checker u_chk (.*);

// ===== dv/tb_multi_deck_sample_mixer_core.sv =====
// testbench for multi_deck_sample_mixer_core: queued requests, predicted tanh mix checked per tick
// depends on mdsm_pkg and the mixer RTL
`timescale 1ns / 100ps

module tb_multi_deck_sample_mixer_core import mdsm_pkg::*;;

	localparam int DECKS = 4;
	localparam int DEPTH = 64;
	localparam int TICK_SETTLE = 3 * DECKS + 40;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic [1:0] mode;
		logic [1:0] deck;
		logic signed [15:0] sample;
		logic [15:0] volume;
		logic last;
	} mix_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [1:0] mode = MODE_TICK;
	logic [1:0] deck = 2'd0;
	logic signed [15:0] sample = 16'sd0;
	logic [15:0] volume = 16'd0;
	logic last = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic signed [15:0] mixed_sample;

	mix_req_t pending_reqs[$];
	logic signed [15:0] expected_mix[$];
	int n_fail = 0, n_accepted = 0, n_ticks_seen = 0;
	longint cycles = 0;

	// predictor state
	longint tanh_lut[0:TBL_LAST];
	logic signed [15:0] deck_samples[int];
	int pos[DECKS], len[DECKS], wptr[DECKS];
	logic [15:0] gain[DECKS];
	bit playing[DECKS], filling[DECKS];

	multi_deck_sample_mixer_core #(.NUM_DECKS(DECKS), .DECK_DEPTH(DEPTH)) dut (
		.clk, .arst_n, .push, .full, .mode, .deck, .sample, .volume, .last,
		.empty, .pop, .mixed_sample
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [15:0] soft_clip_q15(longint mixq29);
		longint u, idx, frac, acc;
		u = mixq29 + 64'sd2147483648;
		if (u < 0) return 16'(tanh_lut[0]);
		if (u >= 64'sd4294967296) return 16'(tanh_lut[TBL_LAST]);
		idx = u >>> FRAC_W;
		frac = u & 64'sh3FFFFF;
		acc = (tanh_lut[idx] + 32768) * (64'sd4194304 - frac)
			+ (tanh_lut[idx + 1] + 32768) * frac + 64'sd2097152;
		return 16'((acc >>> FRAC_W) - 32768);
	endfunction

	task automatic apply_request(input mix_req_t r);
		int d;
		longint mixq29;
		d = r.deck;
		if (r.mode == MODE_LOAD) begin
			if (!filling[d]) begin
				wptr[d] = 0;
				playing[d] = 0;
				filling[d] = 1;
			end
			// an overfull load keeps the pointer pinned at the deck size
			if (wptr[d] < DEPTH) begin
				deck_samples[d * DEPTH + wptr[d]] = r.sample;
				wptr[d]++;
			end
			if (r.last) begin
				len[d] = wptr[d];
				gain[d] = r.volume;
				pos[d] = 0;
				playing[d] = 1;
				filling[d] = 0;
			end
		end else if (r.mode == MODE_VOL) begin
			gain[d] = r.volume;
		end else if (r.mode == MODE_TICK) begin
			mixq29 = 0;
			for (int k = 0; k < DECKS; k++) begin
				if (!playing[k]) continue;
				if (pos[k] >= len[k]) begin
					playing[k] = 0;
					continue;
				end
				mixq29 += longint'(deck_samples[k * DEPTH + pos[k]]) * longint'(gain[k]);
				pos[k]++;
			end
			expected_mix.push_back(soft_clip_q15(mixq29));
		end
	endtask

	function automatic mix_req_t mk(logic [1:0] m, logic [1:0] d, logic signed [15:0] s,
			logic [15:0] v, logic l);
		mix_req_t r;
		r.mode = m; r.deck = d; r.sample = s; r.volume = v; r.last = l;
		return r;
	endfunction

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// driver: bursts of requests with random gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (push && !full) begin
				apply_request('{mode, deck, sample, volume, last});
				n_accepted++;
			end
			if (!push || !full) begin
				if (gap_left > 0) begin
					push <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_reqs.size() > 0) begin
					mix_req_t r;
					r = pending_reqs.pop_front();
					push <= 1'b1;
					mode <= r.mode;
					deck <= r.deck;
					sample <= r.sample;
					volume <= r.volume;
					last <= r.last;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: pop stalls follow a slow phase counter
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			cycles++;
			if (pop && !empty) begin
				n_ticks_seen++;
				if (expected_mix.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %0d", $time,
						mixed_sample);
					n_fail++;
				end else begin
					logic signed [15:0] want;
					want = expected_mix.pop_front();
					if (mixed_sample !== want) begin
						$display("%0t: mixed_sample mismatch, expected %0d actual %0d",
							$time, want, mixed_sample);
						n_fail++;
					end
				end
			end
			case ((cycles / 300) % 4)
				0: pop <= 1'b1;
				1: pop <= ($urandom_range(0, 1) == 0);
				2: pop <= (cycles % 23) < 3;
				default: pop <= ($urandom_range(0, 9) != 0);
			endcase
			if (cycles > CYCLE_LIMIT) begin
				$display("%0t: timeout", $time);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		int n_items, len_run, d;
		// tanh table in Q1.15, odd-symmetric about the midpoint
		begin
			longint unsigned e, num, den;
			e = 64'd1 << 32;
			for (int j = 0; j <= TBL_MID; j++) begin
				num = (64'd1 << 32) - e;
				den = (64'd1 << 32) + e;
				tanh_lut[TBL_MID + j] = longint'((num * 32768 + den / 2) / den);
				tanh_lut[TBL_MID - j] = -tanh_lut[TBL_MID + j];
				e = (e * 64'(EXP_STEP) + (64'd1 << 31)) >> 32;
			end
		end
		for (int k = 0; k < DECKS; k++) begin
			pos[k] = 0; len[k] = 0; wptr[k] = 0;
			gain[k] = UNITY_GAIN; playing[k] = 0; filling[k] = 0;
		end

		// directed: tick with nothing playing, full-scale decks mixed near the top of the clip range
		pending_reqs.push_back(mk(MODE_TICK, 0, 0, 0, 0));
		pending_reqs.push_back(mk(MODE_LOAD, 0, 16'sh7FFF, 0, 0));
		pending_reqs.push_back(mk(MODE_LOAD, 0, 16'sh7FFF, 16'hFFFF, 1));
		pending_reqs.push_back(mk(MODE_LOAD, 1, 16'sh7FFF, 16'hFFFF, 1));
		pending_reqs.push_back(mk(MODE_LOAD, 2, 16'sh8000, 16'h0000, 1));
		pending_reqs.push_back(mk(MODE_LOAD, 3, 16'sh8000, 16'hFFFF, 0));
		pending_reqs.push_back(mk(MODE_LOAD, 3, 16'sh8000, 16'hFFFF, 1));
		pending_reqs.push_back(mk(MODE_TICK, 0, 0, 0, 0));
		pending_reqs.push_back(mk(MODE_VOL, 2, 0, 16'hFFFF, 0));
		pending_reqs.push_back(mk(MODE_TICK, 0, 0, 0, 0));
		pending_reqs.push_back(mk(MODE_UNUSED, 1, 16'sh7FFF, 16'hFFFF, 1)); // ignored
		pending_reqs.push_back(mk(MODE_TICK, 0, 0, 0, 0));
		pending_reqs.push_back(mk(MODE_LOAD, 1, 16'sh4000, 16'd16384, 1));
		pending_reqs.push_back(mk(MODE_TICK, 0, 0, 0, 0));
		pending_reqs.push_back(mk(MODE_TICK, 0, 0, 0, 0));

		// overfull load: samples past the deck size are dropped
		for (int k = 0; k <= DEPTH; k++)
			pending_reqs.push_back(mk(MODE_LOAD, 0, 16'(k * 7), 16'd9000, k == DEPTH));
		pending_reqs.push_back(mk(MODE_TICK, 0, 0, 0, 0));

		// random: mostly complete loads and ticks, some volume changes and noise
		n_items = 0;
		while (n_items < 850) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8: begin
					pending_reqs.push_back(mk(MODE_TICK, 2'($urandom), 16'($urandom),
						16'($urandom), 1'($urandom)));
					n_items++;
				end
				9, 10, 11, 12, 13: begin
					len_run = $urandom_range(1, 12);
					d = $urandom_range(0, 3);
					for (int k = 0; k < len_run; k++)
						pending_reqs.push_back(mk(MODE_LOAD, 2'(d), pick_sample(),
							16'($urandom), k == len_run - 1));
					n_items += len_run;
				end
				14, 15: begin
					pending_reqs.push_back(mk(MODE_VOL, 2'($urandom), 16'($urandom),
						16'($urandom), 1'($urandom)));
					n_items++;
				end
				16: begin
					pending_reqs.push_back(mk(MODE_UNUSED, 2'($urandom), 16'($urandom),
						16'($urandom), 1'($urandom)));
				end
				default: begin
					// broken load: no closing sample, the deck stays silent until reloaded
					pending_reqs.push_back(mk(MODE_LOAD, 2'($urandom), pick_sample(),
						16'($urandom), 1'b0));
					n_items++;
				end
			endcase
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_reqs.size() == 0 && !push && expected_mix.size() == 0);
		repeat (TICK_SETTLE) @(posedge clk);

		$display("%0d requests accepted, %0d mixed samples checked", n_accepted, n_ticks_seen);
		$display("covered full-scale saturation, overfull load, partial loads and gain changes");
		if (n_fail == 0 && expected_mix.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
